// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked every clock edge, reset disabled.
`define ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// File: rtl/core/rssd_pkg.sv
// Package with types and constants of the run-length sprite span decoder.
`default_nettype none
package rssd_pkg;

	localparam logic [7:0] CLEAR_CODE = 8'd255;

	localparam int AddrWidth = 5;

	localparam logic [2:0] REG_ALPHA_MODE    = 3'd0;
	localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd1;
	localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd2;
	localparam logic [2:0] REG_ORIGIN_X      = 3'd3;
	localparam logic [2:0] REG_ORIGIN_Y      = 3'd4;
	localparam logic [2:0] REG_OFF_SHADE     = 3'd5;
	localparam logic [2:0] REG_ON_SHADE      = 3'd6;
	localparam logic [2:0] REG_ALPHA_SHADE   = 3'd7;

	localparam logic [1:0] CODE_OFF   = 2'd0;
	localparam logic [1:0] CODE_ON    = 2'd1;
	localparam logic [1:0] CODE_ALPHA = 2'd2;
	localparam logic [1:0] CODE_NONE  = 2'd3;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic       alpha_mode;
		logic [7:0] width;
		logic [7:0] height;
		logic [7:0] origin_x;
		logic [7:0] origin_y;
		logic [7:0] off_shade;
		logic [7:0] on_shade;
		logic [7:0] alpha_shade;
	} cfg_t;

	typedef struct packed {
		logic [7:0] take;
		logic [7:0] end_col;
		logic       row_end;
		logic       frame_end;
	} seg_res_t;

endpackage
`default_nettype wire

// File: rtl/core/rle_sprite_span_decoder.sv
// Top level of the run-length sprite span decoder.
// Each accepted span byte is split into fill segments that never cross a sprite row, one
// segment per clock while the output is not stalled, from a single shared clip unit; a byte
// that covers k segments (k is at most 64) keeps in_ready low until its final segment has
// been issued, and a zero-length byte is absorbed in its accept cycle. Segments whose
// color is the transparent code still advance the raster position but are not emitted.
// Registers sit at byte address 4*i; sizes below the legal range are used as the minimum.
`default_nettype none
module rle_sprite_span_decoder
	import rssd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [AddrWidth-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           span_byte,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [8:0]           seg_x,
	output logic      [8:0]           seg_y,
	output logic      [7:0]           seg_len,
	output logic      [7:0]           seg_shade,
	output logic                      frame_done,
	output logic                      last
);

	cfg_t cfg;

	rssd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rssd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.span_byte  (span_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.seg_x      (seg_x),
		.seg_y      (seg_y),
		.seg_len    (seg_len),
		.seg_shade  (seg_shade),
		.frame_done (frame_done),
		.last       (last)
	);

endmodule
`default_nettype wire

// File: rtl/core/rssd_cfg.sv
// Configuration register file with APB-style access and size clamping.
`default_nettype none
module rssd_cfg
	import rssd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [AddrWidth-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	logic       alpha_mode_q;
	logic [7:0] width_q;
	logic [7:0] height_q;
	logic [7:0] origin_x_q;
	logic [7:0] origin_y_q;
	logic [7:0] off_shade_q;
	logic [7:0] on_shade_q;
	logic [7:0] alpha_shade_q;
	logic [2:0] index;
	logic       wr_en;

	assign pready = 1'b1;
	assign index  = paddr[AddrWidth-1:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_mode_q  <= 1'b0;
			width_q       <= 8'd16;
			height_q      <= 8'd16;
			origin_x_q    <= 8'd0;
			origin_y_q    <= 8'd0;
			off_shade_q   <= 8'd0;
			on_shade_q    <= 8'd1;
			alpha_shade_q <= 8'd255;
		end else if (wr_en) begin
			unique case (index)
				REG_ALPHA_MODE:    alpha_mode_q  <= pwdata[0];
				REG_SPRITE_WIDTH:  width_q       <= pwdata[7:0];
				REG_SPRITE_HEIGHT: height_q      <= pwdata[7:0];
				REG_ORIGIN_X:      origin_x_q    <= pwdata[7:0];
				REG_ORIGIN_Y:      origin_y_q    <= pwdata[7:0];
				REG_OFF_SHADE:     off_shade_q   <= pwdata[7:0];
				REG_ON_SHADE:      on_shade_q    <= pwdata[7:0];
				REG_ALPHA_SHADE:   alpha_shade_q <= pwdata[7:0];
				default:           ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (index)
			REG_ALPHA_MODE:    prdata = {31'd0, alpha_mode_q};
			REG_SPRITE_WIDTH:  prdata = {24'd0, width_q};
			REG_SPRITE_HEIGHT: prdata = {24'd0, height_q};
			REG_ORIGIN_X:      prdata = {24'd0, origin_x_q};
			REG_ORIGIN_Y:      prdata = {24'd0, origin_y_q};
			REG_OFF_SHADE:     prdata = {24'd0, off_shade_q};
			REG_ON_SHADE:      prdata = {24'd0, on_shade_q};
			REG_ALPHA_SHADE:   prdata = {24'd0, alpha_shade_q};
			default:           prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.alpha_mode  = alpha_mode_q;
		cfg.width       = (width_q < 8'd2) ? 8'd2 : width_q;
		cfg.height      = (height_q == 8'd0) ? 8'd1 : height_q;
		cfg.origin_x    = origin_x_q;
		cfg.origin_y    = origin_y_q;
		cfg.off_shade   = off_shade_q;
		cfg.on_shade    = on_shade_q;
		cfg.alpha_shade = alpha_shade_q;
	end

endmodule
`default_nettype wire

// File: rtl/core/rssd_seg_unit.sv
// Shared segment unit: clips the remaining span length against the row end.
`default_nettype none
module rssd_seg_unit
	import rssd_pkg::*;
(
	input  wire logic [7:0] column,
	input  wire logic [7:0] row,
	input  wire logic [6:0] len,
	input  wire logic [7:0] width,
	input  wire logic [7:0] height,
	output seg_res_t        res
);

	logic [7:0] room;
	logic [8:0] sum;

	always_comb begin
		room          = width - column;
		res.take      = ({1'b0, len} < room) ? {1'b0, len} : room;
		sum           = {1'b0, column} + {1'b0, res.take};
		res.end_col   = sum[7:0];
		res.row_end   = (res.take == room);
		res.frame_end = res.row_end && (row == (height - 8'd1));
	end

endmodule
`default_nettype wire

// File: rtl/core/rssd_seq.sv
// Span sequencer: raster position, span decode and the output register.
`default_nettype none
module rssd_seq
	import rssd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] span_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [8:0] seg_x,
	output logic      [8:0] seg_y,
	output logic      [7:0] seg_len,
	output logic      [7:0] seg_shade,
	output logic            frame_done,
	output logic            last
);

	state_t     state_q, state_d;
	logic [7:0] column_q;
	logic [7:0] row_q;
	logic [6:0] len_q;
	logic [7:0] shade_q;
	logic       vis_q;
	logic       out_valid_q;

	logic       accept;
	logic       step;
	logic       final_seg;
	logic [6:0] in_len;
	logic [1:0] in_code;
	logic [7:0] in_shade;
	logic [7:0] wrap_row;
	logic [7:0] norm_col;
	logic [7:0] norm_row;
	logic [6:0] len_left;
	seg_res_t   res;

	rssd_seg_unit u_seg (
		.column (column_q),
		.row    (row_q),
		.len    (len_q),
		.width  (cfg.width),
		.height (cfg.height),
		.res    (res)
	);

	always_comb begin
		if (cfg.alpha_mode) begin
			in_len  = {1'b0, span_byte[5:0]};
			in_code = span_byte[7:6];
		end else begin
			in_len  = span_byte[6:0];
			in_code = {1'b0, span_byte[7]};
		end
		unique case (in_code)
			CODE_OFF:   in_shade = cfg.off_shade;
			CODE_ON:    in_shade = cfg.on_shade;
			CODE_ALPHA: in_shade = cfg.alpha_shade;
			CODE_NONE:  in_shade = CLEAR_CODE;
			default:    in_shade = CLEAR_CODE;
		endcase
		norm_col = column_q;
		wrap_row = row_q;
		if (column_q >= cfg.width) begin
			norm_col = 8'd0;
			wrap_row = row_q + 8'd1;
		end
		norm_row = wrap_row;
		if (wrap_row >= cfg.height) begin
			norm_col = 8'd0;
			norm_row = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		accept    = 1'b0;
		step      = 1'b0;
		len_left  = len_q - res.take[6:0];
		final_seg = res.frame_end || (len_left == 7'd0);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (in_valid && (in_len != 7'd0)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				step = !out_valid_q || out_ready;
				if (step && final_seg) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= 8'd0;
			row_q    <= 8'd0;
		end else if (accept && (in_len != 7'd0)) begin
			column_q <= norm_col;
			row_q    <= norm_row;
		end else if (step) begin
			if (res.frame_end) begin
				column_q <= 8'd0;
				row_q    <= 8'd0;
			end else if (res.row_end) begin
				column_q <= 8'd0;
				row_q    <= row_q + 8'd1;
			end else begin
				column_q <= res.end_col;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			len_q   <= in_len;
			shade_q <= in_shade;
			vis_q   <= (in_code != CODE_NONE) && (in_shade != CLEAR_CODE);
		end else if (step) begin
			len_q <= len_left;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && vis_q) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && vis_q) begin
			seg_x      <= {1'b0, cfg.origin_x} + {1'b0, column_q};
			seg_y      <= {1'b0, cfg.origin_y} + {1'b0, row_q};
			seg_len    <= res.take;
			seg_shade  <= shade_q;
			frame_done <= res.frame_end;
			last       <= final_seg;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/core/rssd_checker.sv
// Port-level checker for the span decoder and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module rssd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [8:0] seg_x,
	input wire logic [7:0] seg_len,
	input wire logic       frame_done,
	input wire logic       last
);

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(seg_x), "output beat dropped or changed while stalled")
	`ASSERT_IMPL(a_len_nonzero, clk, arst_n, out_valid, seg_len != 8'd0, "empty segment emitted")
	`ASSERT_IMPL(a_done_is_last, clk, arst_n, out_valid && frame_done, last, "frame end not on the final beat of a span")
	`ASSERT_IMPL(a_busy_mid_span, clk, arst_n, out_valid && !last, !in_ready, "new span taken before the current one finished")

endmodule

bind rle_sprite_span_decoder rssd_checker u_rssd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.seg_x      (seg_x),
	.seg_len    (seg_len),
	.frame_done (frame_done),
	.last       (last)
);
`default_nettype wire
